[hdl/late_interaction_maxsim_score_unit_assert.svh]
// Assertion macros shared by the checker of the score unit
`ifndef LATE_INTERACTION_MAXSIM_SCORE_UNIT_ASSERT_SVH
`define LATE_INTERACTION_MAXSIM_SCORE_UNIT_ASSERT_SVH

// Same-cycle implication
`define LIMS_ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication
`define LIMS_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

[hdl/lims_pkg.sv]
// Package: shared types, codes and constants of the score unit
`default_nettype none
package lims_pkg;

  localparam int ELEM_W    = 16;
  localparam int SCORE_W   = 19;
  localparam int WEIGHT_W  = 17;
  localparam int RANK_W    = 7;
  localparam int SCORE_MAX = 131072;
  localparam int WEIGHT_ONE = 65536;

  localparam logic [1:0] ACT_QUERY_GLOBAL = 2'd0;
  localparam logic [1:0] ACT_QUERY_TOKEN  = 2'd1;
  localparam logic [1:0] ACT_ENTRY_GLOBAL = 2'd2;
  localparam logic [1:0] ACT_ENTRY_TOKEN  = 2'd3;

  localparam logic REG_LATE_WEIGHT = 1'b0;
  localparam logic REG_RANK_IN_USE = 1'b1;

  // Control that travels with each beat along the chain
  typedef struct packed {
    logic valid;
    logic firstk;
    logic lastk;
    logic lasti;
    logic kill;
    logic pend_v;
    logic best_v;
  } beat_ctl_t;

  typedef enum logic [2:0] {
    S_IDLE, S_GLOBAL, S_FEED, S_DRAIN, S_POST, S_WAIT, S_OUT
  } seq_state_t;

  typedef enum logic [2:0] {
    P_IDLE, P_DIV, P_LOAD, P_MUL, P_SUM, P_SAT, P_DONE
  } post_state_t;

endpackage
`default_nettype wire

[hdl/lims_cell.sv]
// One chain cell: holds one entry token key, forms its dot product, carries the running best
`default_nettype none
module lims_cell import lims_pkg::*; #(
  parameter int RANK = 64,
  parameter int KW   = 6,
  parameter int DW   = 39
) (
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire logic                     wr_en,
  input  wire logic [KW-1:0]            wr_addr,
  input  wire logic [ELEM_W-1:0]        wr_data,
  input  wire logic                     en,
  input  wire beat_ctl_t                ctl_in,
  input  wire logic [KW-1:0]            k_in,
  input  wire logic signed [ELEM_W-1:0] q_in,
  input  wire logic signed [DW-1:0]     pend_in,
  input  wire logic signed [DW-1:0]     best_in,
  output beat_ctl_t                     ctl_out,
  output logic [KW-1:0]                 k_out,
  output logic signed [ELEM_W-1:0]      q_out,
  output logic signed [DW-1:0]          pend_out,
  output logic signed [DW-1:0]          best_out
);

  logic [ELEM_W-1:0]        mem [RANK];
  logic signed [ELEM_W-1:0] e_rd;
  beat_ctl_t                h_ctl;
  logic [KW-1:0]            h_k;
  logic signed [ELEM_W-1:0] h_q;
  logic signed [DW-1:0]     h_pend;
  logic signed [DW-1:0]     h_best;
  logic signed [DW-1:0]     acc;
  logic signed [31:0]       prod;
  logic signed [DW-1:0]     acc_sum;
  logic                     take;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    e_rd <= mem[k_in];
  end

  always_comb begin
    prod    = h_ctl.kill ? 32'sd0 : h_q * e_rd;
    acc_sum = (h_ctl.firstk ? '0 : acc) + DW'(prod);
    take    = h_ctl.pend_v && (!h_ctl.best_v || (h_pend > h_best));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      h_ctl   <= '0;
      ctl_out <= '0;
    end else begin
      h_ctl <= ctl_in;
      ctl_out.valid  <= h_ctl.valid;
      ctl_out.firstk <= h_ctl.firstk;
      ctl_out.lastk  <= h_ctl.lastk;
      ctl_out.lasti  <= h_ctl.lasti;
      ctl_out.kill   <= h_ctl.kill;
      // fold the previous cell's dot into the best, hand ours on as pending
      ctl_out.pend_v <= en;
      ctl_out.best_v <= h_ctl.pend_v | h_ctl.best_v;
    end
  end

  always_ff @(posedge clk) begin
    h_k    <= k_in;
    h_q    <= q_in;
    h_pend <= pend_in;
    h_best <= best_in;
    if (h_ctl.valid) begin
      acc <= acc_sum;
    end
    k_out    <= h_k;
    q_out    <= h_q;
    pend_out <= acc_sum;
    best_out <= take ? h_pend : h_best;
  end

endmodule
`default_nettype wire

[hdl/lims_post.sv]
// Post unit: late sum divided by query count, weighted, global term added, saturated
`default_nettype none
module lims_post import lims_pkg::*; #(
  parameter int LW = 45,
  parameter int QW = 6,
  parameter int DW = 39
) (
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire logic                     start,
  input  wire logic signed [LW-1:0]     late,
  input  wire logic [QW-1:0]            divisor,
  input  wire logic [WEIGHT_W-1:0]      weight,
  input  wire logic signed [DW-1:0]     gdot,
  output logic                          done,
  output logic signed [SCORE_W-1:0]     score
);

  localparam int PW = LW + WEIGHT_W + 1;
  localparam int CW = $clog2(LW + 1);

  post_state_t           pst, pst_next;
  logic [LW-1:0]         quo;
  logic [QW-1:0]         rem;
  logic                  neg;
  logic [CW-1:0]         cnt;
  logic signed [PW-1:0]  prod;
  logic signed [PW-1:0]  msh;
  logic [WEIGHT_W-1:0]   wsh;
  logic signed [PW-1:0]  total;
  logic [QW:0]           rem_sh;
  logic                  ge;
  logic [QW:0]           rem_new;
  logic signed [LW-1:0]  avg;
  logic signed [PW-1:0]  q16;
  logic                  div_last;
  logic                  mul_last;

  always_comb begin
    rem_sh   = {rem, quo[LW-1]};
    ge       = rem_sh >= {1'b0, divisor};
    rem_new  = ge ? (rem_sh - {1'b0, divisor}) : rem_sh;
    avg      = neg ? -$signed(quo) : $signed(quo);
    q16      = total >>> 14;
    div_last = cnt == CW'(LW - 1);
    mul_last = cnt == CW'(WEIGHT_W - 1);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pst <= P_IDLE;
    end else begin
      pst <= pst_next;
    end
  end

  always_comb begin
    pst_next = pst;
    done     = 1'b0;
    unique case (pst)
      P_IDLE: if (start) pst_next = P_DIV;
      P_DIV:  if (div_last) pst_next = P_LOAD;
      P_LOAD: pst_next = P_MUL;
      P_MUL:  if (mul_last) pst_next = P_SUM;
      P_SUM:  pst_next = P_SAT;
      P_SAT:  pst_next = P_DONE;
      P_DONE: begin
        done     = 1'b1;
        pst_next = P_IDLE;
      end
      default: pst_next = P_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    unique case (pst)
      P_IDLE: begin
        // truncate toward zero: divide the magnitude, restore the sign
        neg <= late[LW-1];
        quo <= late[LW-1] ? LW'(-late) : LW'(late);
        rem <= '0;
        cnt <= '0;
      end
      P_DIV: begin
        rem <= rem_new[QW-1:0];
        quo <= {quo[LW-2:0], ge};
        cnt <= cnt + CW'(1);
      end
      P_LOAD: begin
        msh  <= PW'(avg);
        prod <= '0;
        wsh  <= weight;
        cnt  <= '0;
      end
      P_MUL: begin
        if (wsh[0]) begin
          prod <= prod + msh;
        end
        msh <= msh <<< 1;
        wsh <= wsh >> 1;
        cnt <= cnt + CW'(1);
      end
      P_SUM: total <= PW'(gdot) + (prod >>> 16);
      P_SAT: begin
        if (q16 > PW'(SCORE_MAX)) begin
          score <= SCORE_W'(SCORE_MAX);
        end else if (q16 < -PW'(SCORE_MAX)) begin
          score <= -SCORE_W'(SCORE_MAX);
        end else begin
          score <= q16[SCORE_W-1:0];
        end
      end
      P_DONE: ;
      default: ;
    endcase
  end

endmodule
`default_nettype wire

[hdl/late_interaction_maxsim_score_unit.sv]
// Top level: key stores, scoring sequencer, cell chain and output register
// Usage:
//   Load beats arrive on in_valid/in_ready, one key element per beat, and each
//   is taken in the cycle it is offered while the unit is idle. A beat with
//   last set is stored and then starts scoring; no further beat is taken
//   until the score has been placed in the output register.
//   Scoring runs over an effective rank r of at least 1; the late sum is LW
//   bits wide, 45 at the default sizes. The query-token loop streams one
//   element per cycle into a chain of MAX_ENTRY_TOKENS cells, one per entry
//   token, each cell registered at its input and at its output; a serial
//   divider and a shift-add weight multiplier then finish the score.
//   A zero query or entry count skips scoring and gives -2.0.
//   The score is held on out_valid/score until out_ready; a stalled receiver
//   holds the unit before it takes new load beats.
//   cfg_we writes the late-term weight (index 0) or rank_in_use (index 1) at once.
//   Reset restores the register defaults; key stores are not cleared and must
//   be written before they are used.
`default_nettype none
module late_interaction_maxsim_score_unit import lims_pkg::*; #(
  parameter int RANK             = 64,
  parameter int MAX_QUERY_TOKENS = 32,
  parameter int MAX_ENTRY_TOKENS = 32
) (
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire logic                     cfg_we,
  input  wire logic                     cfg_index,
  input  wire logic [WEIGHT_W-1:0]      cfg_data,
  input  wire logic                     in_valid,
  output logic                          in_ready,
  input  wire logic [1:0]               action,
  input  wire logic [4:0]               token_index,
  input  wire logic [5:0]               element_index,
  input  wire logic signed [ELEM_W-1:0] key_element,
  input  wire logic [5:0]               query_count,
  input  wire logic [5:0]               entry_count,
  input  wire logic                     last,
  output logic                          out_valid,
  input  wire logic                     out_ready,
  output logic signed [SCORE_W-1:0]     score
);

  localparam int KW     = (RANK > 1) ? $clog2(RANK) : 1;
  localparam int KCW    = $clog2(RANK + 1);
  localparam int QW     = $clog2(MAX_QUERY_TOKENS + 1);
  localparam int EW     = $clog2(MAX_ENTRY_TOKENS + 1);
  localparam int QIW    = (MAX_QUERY_TOKENS > 1) ? $clog2(MAX_QUERY_TOKENS) : 1;
  localparam int QDEPTH = MAX_QUERY_TOKENS * RANK;
  localparam int QAW    = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int DW     = 33 + $clog2(RANK);
  localparam int LW     = DW + $clog2(MAX_QUERY_TOKENS) + 1;

  // configuration
  logic [WEIGHT_W-1:0] late_gain;
  logic [RANK_W-1:0]   rank_in_use;
  logic [WEIGHT_W-1:0] w_eff;
  logic [KCW-1:0]      r_eff;

  always_ff @(posedge clk) begin
    if (rst) begin
      late_gain   <= WEIGHT_W'(32768);
      rank_in_use <= RANK_W'(64);
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_LATE_WEIGHT: late_gain <= cfg_data;
        REG_RANK_IN_USE: rank_in_use <= cfg_data[RANK_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    w_eff = (late_gain > WEIGHT_W'(WEIGHT_ONE)) ? WEIGHT_W'(WEIGHT_ONE) : late_gain;
    r_eff = (32'(rank_in_use) > RANK) ? KCW'(RANK) : KCW'(rank_in_use);
  end

  // load side
  logic            acc_in;
  logic            elem_ok;
  logic            qtok_ok;
  logic [KW-1:0]   elem_addr;
  logic [QAW-1:0]  qwr_addr;
  logic [QW-1:0]   nq_in;
  logic [EW-1:0]   ne_in;

  always_comb begin
    acc_in    = in_valid && in_ready;
    elem_ok   = 32'(element_index) < RANK;
    qtok_ok   = 32'(token_index) < MAX_QUERY_TOKENS;
    elem_addr = KW'(element_index);
    qwr_addr  = QAW'(32'(token_index) * RANK + 32'(element_index));
    nq_in     = (32'(query_count) > MAX_QUERY_TOKENS) ? QW'(MAX_QUERY_TOKENS)
                                                       : QW'(query_count);
    ne_in     = (32'(entry_count) > MAX_ENTRY_TOKENS) ? EW'(MAX_ENTRY_TOKENS)
                                                       : EW'(entry_count);
  end

  logic [ELEM_W-1:0] qg_mem [RANK];
  logic [ELEM_W-1:0] eg_mem [RANK];
  logic [ELEM_W-1:0] qt_mem [QDEPTH];

  // sequencer
  seq_state_t     state, state_next;
  logic [KW-1:0]  k;
  logic [QIW-1:0] i;
  logic [QAW-1:0] base;
  logic [KCW-1:0] klim;
  logic [QW-1:0]  nq_r;
  logic [EW-1:0]  ne_r;
  logic           kill_r;
  logic           zc_r;
  logic           k_last;
  logic           i_last;
  logic           post_start;
  logic           post_done;
  logic           load_out;
  logic           tb_v, tb_lasti;
  logic signed [SCORE_W-1:0] post_score;

  logic signed [ELEM_W-1:0] gq_rd, ge_rd, q_rd;
  logic                     g_v, g_first;
  logic signed [DW-1:0]     gacc;
  logic signed [31:0]       gprod;

  logic           iss_v, iss_first, iss_lastk, iss_lasti;
  logic [KW-1:0]  iss_k;

  always_comb begin
    k_last = (KCW'(k) + KCW'(1)) == klim;
    i_last = (QW'(i) + QW'(1)) == nq_r;
  end

  always_ff @(posedge clk) begin
    if (acc_in && elem_ok) begin
      unique case (action)
        ACT_QUERY_GLOBAL: qg_mem[elem_addr] <= key_element;
        ACT_ENTRY_GLOBAL: eg_mem[elem_addr] <= key_element;
        ACT_QUERY_TOKEN:  if (qtok_ok) qt_mem[qwr_addr] <= key_element;
        ACT_ENTRY_TOKEN:  ;
        default: ;
      endcase
    end
    gq_rd <= qg_mem[k];
    ge_rd <= eg_mem[k];
    q_rd  <= qt_mem[base + QAW'(k)];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    in_ready   = 1'b0;
    post_start = 1'b0;
    load_out   = 1'b0;
    unique case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid && last) begin
          state_next = ((query_count == '0) || (entry_count == '0)) ? S_OUT : S_GLOBAL;
        end
      end
      S_GLOBAL: if (k_last) state_next = S_FEED;
      S_FEED:   if (k_last && i_last) state_next = S_DRAIN;
      S_DRAIN:  ;
      S_POST: begin
        post_start = 1'b1;
        state_next = S_WAIT;
      end
      S_WAIT: if (post_done) state_next = S_OUT;
      S_OUT: begin
        if (!out_valid || out_ready) begin
          load_out   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
    if (state == S_DRAIN && tb_v && tb_lasti) begin
      state_next = S_POST;
    end
  end

  // counters and issue stage
  always_ff @(posedge clk) begin
    if (rst) begin
      k     <= '0;
      i     <= '0;
      base  <= '0;
      iss_v <= 1'b0;
      g_v   <= 1'b0;
    end else begin
      iss_v <= 1'b0;
      g_v   <= 1'b0;
      if (acc_in && last) begin
        k    <= '0;
        i    <= '0;
        base <= '0;
      end
      if (state == S_GLOBAL) begin
        g_v     <= 1'b1;
        g_first <= k == '0;
        k       <= k_last ? '0 : k + KW'(1);
      end
      if (state == S_FEED) begin
        iss_v     <= 1'b1;
        iss_first <= k == '0;
        iss_lastk <= k_last;
        iss_lasti <= i_last;
        iss_k     <= k;
        if (k_last) begin
          k    <= '0;
          i    <= i + QIW'(1);
          base <= base + QAW'(RANK);
        end else begin
          k <= k + KW'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (acc_in && last) begin
      nq_r   <= nq_in;
      ne_r   <= ne_in;
      klim   <= (r_eff == '0) ? KCW'(1) : r_eff;
      kill_r <= r_eff == '0;
      zc_r   <= (query_count == '0) || (entry_count == '0);
    end
  end

  // global dot product
  always_comb begin
    gprod = kill_r ? 32'sd0 : gq_rd * ge_rd;
  end

  always_ff @(posedge clk) begin
    if (g_v) begin
      gacc <= (g_first ? '0 : gacc) + DW'(gprod);
    end
  end

  // cell chain
  beat_ctl_t                ctl_w  [MAX_ENTRY_TOKENS+1];
  logic [KW-1:0]            k_w    [MAX_ENTRY_TOKENS+1];
  logic signed [ELEM_W-1:0] q_w    [MAX_ENTRY_TOKENS+1];
  logic signed [DW-1:0]     pend_w [MAX_ENTRY_TOKENS+1];
  logic signed [DW-1:0]     best_w [MAX_ENTRY_TOKENS+1];
  logic [MAX_ENTRY_TOKENS-1:0] en;

  always_comb begin
    ctl_w[0].valid  = iss_v;
    ctl_w[0].firstk = iss_first;
    ctl_w[0].lastk  = iss_lastk;
    ctl_w[0].lasti  = iss_lasti;
    ctl_w[0].kill   = kill_r;
    ctl_w[0].pend_v = 1'b0;
    ctl_w[0].best_v = 1'b0;
    k_w[0]    = iss_k;
    q_w[0]    = q_rd;
    pend_w[0] = '0;
    best_w[0] = '0;
  end

  always_ff @(posedge clk) begin
    for (int t = 0; t < MAX_ENTRY_TOKENS; t++) begin
      en[t] <= 32'(ne_r) > t;
    end
  end

  for (genvar j = 0; j < MAX_ENTRY_TOKENS; j++) begin : g_cell
    logic wr_en;

    always_comb begin
      wr_en = acc_in && (action == ACT_ENTRY_TOKEN) && elem_ok && (32'(token_index) == j);
    end

    lims_cell #(
      .RANK (RANK),
      .KW   (KW),
      .DW   (DW)
    ) u_cell (
      .clk      (clk),
      .rst      (rst),
      .wr_en    (wr_en),
      .wr_addr  (elem_addr),
      .wr_data  (key_element),
      .en       (en[j]),
      .ctl_in   (ctl_w[j]),
      .k_in     (k_w[j]),
      .q_in     (q_w[j]),
      .pend_in  (pend_w[j]),
      .best_in  (best_w[j]),
      .ctl_out  (ctl_w[j+1]),
      .k_out    (k_w[j+1]),
      .q_out    (q_w[j+1]),
      .pend_out (pend_w[j+1]),
      .best_out (best_w[j+1])
    );
  end

  // chain tail: last merge, then late sum
  beat_ctl_t            ctl_c;
  logic signed [DW-1:0] pend_c, best_c;
  logic                 take_c;
  logic signed [DW-1:0] tb;
  logic signed [LW-1:0] late;

  always_comb begin
    ctl_c  = ctl_w[MAX_ENTRY_TOKENS];
    pend_c = pend_w[MAX_ENTRY_TOKENS];
    best_c = best_w[MAX_ENTRY_TOKENS];
    take_c = ctl_c.pend_v && (!ctl_c.best_v || (pend_c > best_c));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tb_v <= 1'b0;
    end else begin
      tb_v <= ctl_c.valid && ctl_c.lastk;
    end
  end

  always_ff @(posedge clk) begin
    tb_lasti <= ctl_c.lasti;
    tb       <= take_c ? pend_c : best_c;
    if (acc_in && last) begin
      late <= '0;
    end else if (tb_v) begin
      late <= late + LW'(tb);
    end
  end

  lims_post #(
    .LW (LW),
    .QW (QW),
    .DW (DW)
  ) u_post (
    .clk     (clk),
    .rst     (rst),
    .start   (post_start),
    .late    (late),
    .divisor (nq_r),
    .weight  (w_eff),
    .gdot    (gacc),
    .done    (post_done),
    .score   (post_score)
  );

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_out) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      score <= zc_r ? -SCORE_W'(SCORE_MAX) : post_score;
    end
  end

endmodule
`default_nettype wire

[hdl/lims_checker.sv]
// Port checker for the score unit and its bind
`default_nettype none
`include "late_interaction_maxsim_score_unit_assert.svh"
module lims_checker import lims_pkg::*; (
  input wire logic                     clk,
  input wire logic                     rst,
  input wire logic                     in_valid,
  input wire logic                     in_ready,
  input wire logic                     last,
  input wire logic                     out_valid,
  input wire logic                     out_ready,
  input wire logic signed [SCORE_W-1:0] score
);

  `LIMS_ASSERT_NEXT(a_out_hold, clk, rst, out_valid && !out_ready, out_valid && $stable(score), "score beat dropped or changed while stalled")
  `LIMS_ASSERT_IMPL(a_score_range, clk, rst, out_valid, ($signed(score) <= 19'sd131072) && ($signed(score) >= -19'sd131072), "score outside plus or minus 2.0")
  `LIMS_ASSERT_NEXT(a_busy_after_last, clk, rst, in_valid && in_ready && last, !in_ready, "load beat taken while scoring")
  `LIMS_ASSERT_IMPL(a_out_from_busy, clk, rst, $rose(out_valid), $past(!in_ready), "score beat appeared while idle")

endmodule

bind late_interaction_maxsim_score_unit lims_checker u_lims_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .last      (last),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .score     (score)
);
`default_nettype wire

[tb/tb_late_interaction_maxsim_score_unit.sv]
// Testbench for the late-interaction MaxSim score unit: random load beats, scored and checked
`timescale 1ns / 100ps
`default_nettype none

import lims_pkg::*;

class score_board;
  logic signed [15:0] qry_glob[64];
  logic signed [15:0] ent_glob[64];
  logic signed [15:0] qry_tok[2048];
  logic signed [15:0] ent_tok[2048];
  int unsigned weight;
  int unsigned rank_cfg;
  logic [SCORE_W-1:0] pending_scores[$];
  int errors;

  function new();
    weight = 32768;
    rank_cfg = 64;
    errors = 0;
  endfunction

  function void set_reg(logic idx, int unsigned val);
    if (idx == REG_LATE_WEIGHT) weight = val & 17'h1FFFF;
    else rank_cfg = val & 7'h7F;
  endfunction

  function longint dot_prod(int qb, int eb, bit glob, int r);
    longint acc;
    acc = 0;
    for (int k = 0; k < r; k++) begin
      if (glob) acc += longint'(qry_glob[k]) * longint'(ent_glob[k]);
      else acc += longint'(qry_tok[qb + k]) * longint'(ent_tok[eb + k]);
    end
    return acc;
  endfunction

  function longint maxsim_score(int unsigned nq, int unsigned ne);
    int r;
    longint w, glob, late, best, d, avg, total, q16;
    r = (rank_cfg > 64) ? 64 : rank_cfg;
    w = (weight > WEIGHT_ONE) ? WEIGHT_ONE : weight;
    if (nq == 0 || ne == 0) return -SCORE_MAX;
    if (nq > 32) nq = 32;
    if (ne > 32) ne = 32;
    glob = dot_prod(0, 0, 1'b1, r);
    late = 0;
    for (int i = 0; i < nq; i++) begin
      best = 0;
      for (int j = 0; j < ne; j++) begin
        d = dot_prod(i * 64, j * 64, 1'b0, r);
        if (j == 0 || d > best) best = d;
      end
      late += best;
    end
    avg = late / longint'(nq);
    total = glob + ((avg * w) >>> 16);
    q16 = total >>> 14;
    if (q16 > SCORE_MAX) q16 = SCORE_MAX;
    if (q16 < -SCORE_MAX) q16 = -SCORE_MAX;
    return q16;
  endfunction

  function void note_beat(logic [1:0] act, logic [4:0] tok, logic [5:0] elem,
                          logic signed [15:0] val, logic [5:0] nq, logic [5:0] ne,
                          logic lst);
    longint s;
    case (act)
      ACT_QUERY_GLOBAL: qry_glob[elem] = val;
      ACT_ENTRY_GLOBAL: ent_glob[elem] = val;
      ACT_QUERY_TOKEN:  qry_tok[tok * 64 + elem] = val;
      default:          ent_tok[tok * 64 + elem] = val;
    endcase
    if (lst) begin
      s = maxsim_score(nq, ne);
      pending_scores.push_back(s[SCORE_W-1:0]);
    end
  endfunction

  function void check_score(logic [SCORE_W-1:0] got);
    logic [SCORE_W-1:0] want;
    if (pending_scores.size() == 0) begin
      $display("%0t: unexpected score, expected none, actual %0d", $time, $signed(got));
      errors++;
      return;
    end
    want = pending_scores.pop_front();
    if (got !== want) begin
      $display("%0t: score mismatch, expected %0d, actual %0d", $time,
               $signed(want), $signed(got));
      errors++;
    end
  endfunction
endclass

module tb_late_interaction_maxsim_score_unit;
  logic clk = 1'b0;
  logic rst;
  logic cfg_we;
  logic cfg_index;
  logic [WEIGHT_W-1:0] cfg_data;
  logic in_valid;
  logic in_ready;
  logic [1:0] action;
  logic [4:0] token_index;
  logic [5:0] element_index;
  logic signed [ELEM_W-1:0] key_element;
  logic [5:0] query_count;
  logic [5:0] entry_count;
  logic last;
  logic out_valid;
  logic out_ready;
  logic signed [SCORE_W-1:0] score;

  score_board sb;
  int send_idle;
  int recv_idle;
  int beats_sent;

  late_interaction_maxsim_score_unit dut (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_ready(in_ready), .action(action),
    .token_index(token_index), .element_index(element_index),
    .key_element(key_element), .query_count(query_count),
    .entry_count(entry_count), .last(last), .out_valid(out_valid),
    .out_ready(out_ready), .score(score)
  );

  always #5 clk = ~clk;

  initial begin
    #20ms;
    $display("late_interaction_maxsim_score_unit test failed");
    $finish;
  end

  // receiver: random stalls, check each accepted score
  initial begin
    out_ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && out_valid && out_ready) sb.check_score(score);
      out_ready <= ($urandom_range(99) >= recv_idle);
    end
  end

  function automatic logic signed [15:0] rand_elem();
    case ($urandom_range(7))
      0: return 16'sh8000;
      1: return 16'sh7FFF;
      2, 3: return 16'($urandom);
      default: return $signed(16'($urandom_range(1023))) - 16'sd512;
    endcase
  endfunction

  task automatic send_beat(logic [1:0] act, logic [4:0] tok, logic [5:0] elem,
                           logic signed [15:0] val, logic [5:0] nq, logic [5:0] ne,
                           logic lst);
    while ($urandom_range(99) < send_idle) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    action <= act;
    token_index <= tok;
    element_index <= elem;
    key_element <= val;
    query_count <= nq;
    entry_count <= ne;
    last <= lst;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sb.note_beat(act, tok, elem, val, nq, ne, lst);
    beats_sent++;
  endtask

  task automatic write_regs(int unsigned wgt, int unsigned rnk);
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.pending_scores.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= REG_LATE_WEIGHT;
    cfg_data <= WEIGHT_W'(wgt);
    @(posedge clk);
    sb.set_reg(REG_LATE_WEIGHT, wgt);
    cfg_index <= REG_RANK_IN_USE;
    cfg_data <= WEIGHT_W'(rnk);
    @(posedge clk);
    sb.set_reg(REG_RANK_IN_USE, rnk);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  // above rank one only token 0 is loaded in full, so keep each count at one or zero
  task automatic random_count(output logic [5:0] nq, output logic [5:0] ne,
                              input bit narrow);
    int sel;
    sel = $urandom_range(19);
    nq = 6'($urandom_range(1, 6));
    ne = 6'($urandom_range(1, 6));
    if (narrow) begin
      nq = 6'd1;
      ne = 6'd1;
    end
    if (sel == 0) nq = 6'd0;
    else if (sel == 1) ne = 6'd0;
    else if (narrow) ;
    else if (sel == 2) nq = 6'($urandom_range(33, 63));
    else if (sel == 3) ne = 6'($urandom_range(33, 63));
    else if (sel < 6) begin
      nq = 6'($urandom_range(1, 32));
      ne = 6'($urandom_range(1, 32));
    end
  endtask

  task automatic random_segment(int n);
    logic [5:0] nq, ne;
    int start;
    start = beats_sent;
    while (beats_sent - start < n) begin
      // a burst of loads closed by a scoring beat
      repeat ($urandom_range(0, 3))
        send_beat(2'($urandom), 5'($urandom), 6'($urandom), rand_elem(),
                  6'($urandom), 6'($urandom), 1'b0);
      random_count(nq, ne, sb.rank_cfg > 1);
      send_beat(2'($urandom), 5'($urandom), 6'($urandom), rand_elem(), nq, ne, 1'b1);
    end
  endtask

  initial begin
    sb = new();
    beats_sent = 0;
    send_idle = 19;
    recv_idle = 65;
    rst <= 1'b1;
    cfg_we <= 1'b0;
    cfg_index <= REG_LATE_WEIGHT;
    cfg_data <= '0;
    in_valid <= 1'b0;
    action <= ACT_QUERY_GLOBAL;
    token_index <= '0;
    element_index <= '0;
    key_element <= '0;
    query_count <= 6'd1;
    entry_count <= 6'd1;
    last <= 1'b0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // load full global keys and token 0, and element 0 of every other token
    for (int e = 0; e < 64; e++) begin
      send_beat(ACT_QUERY_GLOBAL, 5'd0, 6'(e), rand_elem(), 6'd1, 6'd1, 1'b0);
      send_beat(ACT_ENTRY_GLOBAL, 5'd0, 6'(e), rand_elem(), 6'd1, 6'd1, 1'b0);
      send_beat(ACT_QUERY_TOKEN, 5'd0, 6'(e), rand_elem(), 6'd1, 6'd1, 1'b0);
      send_beat(ACT_ENTRY_TOKEN, 5'd0, 6'(e), rand_elem(), 6'd1, 6'd1, 1'b0);
    end
    for (int t = 1; t < 32; t++) begin
      send_beat(ACT_QUERY_TOKEN, 5'(t), 6'd0, rand_elem(), 6'd1, 6'd1, 1'b0);
      send_beat(ACT_ENTRY_TOKEN, 5'(t), 6'd0, rand_elem(), 6'd1, 6'd1, 1'b0);
    end

    // directed: extremes, zero and oversized counts
    send_beat(ACT_QUERY_GLOBAL, 5'd0, 6'd0, 16'sh8000, 6'd1, 6'd1, 1'b1);
    send_beat(ACT_ENTRY_GLOBAL, 5'd31, 6'd63, 16'sh7FFF, 6'd1, 6'd1, 1'b1);
    send_beat(ACT_QUERY_TOKEN, 5'd31, 6'd63, 16'sh8000, 6'd0, 6'd5, 1'b1);
    send_beat(ACT_ENTRY_TOKEN, 5'd31, 6'd0, 16'sh7FFF, 6'd5, 6'd0, 1'b1);
    send_beat(ACT_ENTRY_TOKEN, 5'd0, 6'd63, 16'sh0000, 6'd1, 6'd1, 1'b1);
    send_beat(ACT_QUERY_TOKEN, 5'd0, 6'd0, 16'shFFFF, 6'd0, 6'd0, 1'b1);
    write_regs(0, 1);
    send_beat(ACT_QUERY_GLOBAL, 5'd0, 6'd1, 16'sh0001, 6'd3, 6'd4, 1'b1);
    send_beat(ACT_ENTRY_GLOBAL, 5'd0, 6'd0, 16'sh8000, 6'd32, 6'd1, 1'b1);
    send_beat(ACT_ENTRY_TOKEN, 5'd0, 6'd0, 16'sh8000, 6'd63, 6'd63, 1'b1);
    write_regs(131071, 127);
    send_beat(ACT_QUERY_TOKEN, 5'd1, 6'd2, 16'sh7FFF, 6'd1, 6'd1, 1'b1);
    send_beat(ACT_ENTRY_TOKEN, 5'd2, 6'd3, 16'sh8000, 6'd1, 6'd1, 1'b1);
    write_regs(65536, 0);
    send_beat(ACT_QUERY_GLOBAL, 5'd3, 6'd4, 16'sh1234, 6'd7, 6'd7, 1'b1);

    random_segment(20);
    write_regs($urandom_range(0, 65536), $urandom_range(1, 64));
    random_segment(20);
    send_idle = 65;
    recv_idle = 19;
    write_regs(65536, 64);
    random_segment(20);
    write_regs($urandom_range(65537, 131071), $urandom_range(65, 127));
    random_segment(20);
    send_idle = 0;
    recv_idle = 0;
    write_regs(32768, $urandom_range(0, 1));
    random_segment(20);
    write_regs($urandom_range(0, 131071), 64);
    random_segment(20);

    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.pending_scores.size() != 0) @(posedge clk);
    repeat (50) @(posedge clk);
    if (sb.errors == 0 && sb.pending_scores.size() == 0)
      $display("late_interaction_maxsim_score_unit test passed");
    else
      $display("late_interaction_maxsim_score_unit test failed");
    $finish;
  end
endmodule

`default_nettype wire

[filelist.f]
+incdir+hdl
hdl/lims_pkg.sv
hdl/lims_cell.sv
hdl/lims_post.sv
hdl/late_interaction_maxsim_score_unit.sv
hdl/lims_checker.sv
tb/tb_late_interaction_maxsim_score_unit.sv
